// ----- src/bgf_pkg.sv -----
// shared constants and types for the battery gauge filter
package bgf_pkg;

  localparam int unsigned MvW      = 15;
  localparam int unsigned PinW     = 12;
  localparam int unsigned GainW    = 12;
  localparam int unsigned AlphaW   = 16;
  localparam int unsigned HoldW    = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned AccW     = 31;
  localparam int unsigned SocPts   = 11;
  localparam int unsigned SegW     = 4;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] RegDividerGain = 2'd0;
  localparam logic [1:0] RegEmaAlpha    = 2'd1;
  localparam logic [1:0] RegRiseHoldoff = 2'd2;

  localparam logic [GainW-1:0]  GainReset  = 12'd512;
  localparam logic [AlphaW-1:0] AlphaReset = 16'd6554;
  localparam logic [HoldW-1:0]  HoldReset  = 8'd30;

  localparam logic [PctW-1:0] PctFull = 7'd100;

  typedef logic [MvW-1:0] mv_t;

  localparam mv_t SocTable [SocPts] = '{
    15'd3000, 15'd3500, 15'd3600, 15'd3680, 15'd3740, 15'd3770,
    15'd3800, 15'd3850, 15'd3950, 15'd4050, 15'd4200
  };

endpackage

// ----- src/battery_gauge_filter_core.sv -----
// battery gauge filter core: scaling, median, ema and charge percent mapping
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------------
//   in      | input     | in_valid_i/in_ready_o   | pin_mv_i, sample_ok_i
//   out     | output    | out_valid_o/out_ready_i | filtered_mv_o, charge_percent_o, level_valid_o
//   cfg     | input     | apb psel/penable/pready | pwrite, paddr, pwdata, prdata
//
// for a good sample the shared 17x31 multiplier runs up to three passes, the median
// scans one candidate a cycle, the segment search walks the table one entry a cycle
// and the divide yields a 4-bit quotient; a bad sample skips to the result stage;
// in_ready_o is high only while the sequencer is idle
// a waiting result does not block a new transaction; a held result holds the sequencer
// reset clears all control and configuration state at once, no clearing pass
module battery_gauge_filter_core #(
  parameter int unsigned MEDIAN_TAPS = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bgf_pkg::PinW-1:0]         pin_mv_i,
  input  logic                             sample_ok_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bgf_pkg::MvW-1:0]          filtered_mv_o,
  output logic [bgf_pkg::PctW-1:0]         charge_percent_o,
  output logic                             level_valid_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgf_pkg::CfgAddrW-1:0]     paddr,
  input  logic [bgf_pkg::CfgDataW-1:0]     pwdata,
  output logic [bgf_pkg::CfgDataW-1:0]     prdata,
  output logic                             pready
);
  import bgf_pkg::*;

  localparam int unsigned SlotW = $clog2(MEDIAN_TAPS);
  localparam int unsigned Mid   = MEDIAN_TAPS / 2;
  localparam logic [SlotW-1:0] MidRank  = SlotW'(Mid);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MEDIAN_TAPS - 1);
  localparam logic [SlotW-1:0] FirstNext = SlotW'(1 % MEDIAN_TAPS);

  typedef enum logic [3:0] {
    StIdle, StScale, StScaled, StMedian, StMulA, StMulB, StAccum,
    StSeg, StScan, StDivide, StReport, StDone
  } state_e;

  state_e            state_q, state_d;
  logic [GainW-1:0]  gain_q, gain_d;
  logic [AlphaW-1:0] alpha_q, alpha_d;
  logic [HoldW-1:0]  hold_q, hold_d;
  logic [PinW-1:0]   pin_q, pin_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [SlotW-1:0]  cand_q, cand_d;
  mv_t               med_q, med_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   sum_q, sum_d;
  logic [47:0]       prod_q, prod_d;
  logic              primed_q, primed_d;
  logic [PctW-1:0]   rep_q, rep_d;
  logic              has_rep_q, has_rep_d;
  logic              pend_q, pend_d;
  logic [HoldW-1:0]  cnt_q, cnt_d;
  logic [PctW-1:0]   pct_q, pct_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [12:0]       rem_q, rem_d;
  logic [8:0]        div_q, div_d;
  logic [1:0]        step_q, step_d;
  logic [3:0]        quo_q, quo_d;
  logic              out_valid_q, out_valid_d;
  mv_t               out_mv_q, out_mv_d;
  logic [PctW-1:0]   out_pct_q, out_pct_d;
  logic              out_lvl_q, out_lvl_d;

  mv_t ring_q [MEDIAN_TAPS];

  logic [16:0]      mul_a;
  logic [AccW-1:0]  mul_b;
  mv_t              mv_now;
  logic             ring_fill, ring_wr;
  logic [SlotW-1:0] rank;
  mv_t              ema_mv;
  logic [11:0]      div_sh;
  logic [8:0]       seg_diff;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      RegDividerGain: prdata = CfgDataW'(gain_q);
      RegEmaAlpha:    prdata = CfgDataW'(alpha_q);
      RegRiseHoldoff: prdata = CfgDataW'(hold_q);
      default:        prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      StScale: begin
        mul_a = 17'(pin_q);
        mul_b = AccW'(gain_q);
      end
      StMulA: begin
        mul_a = 17'(alpha_q);
        mul_b = AccW'(med_q);
      end
      StMulB: begin
        mul_a = 17'h10000 - 17'(alpha_q);
        mul_b = acc_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = 48'(mul_a) * 48'(mul_b);
  assign mv_now = prod_q[23] ? 15'h7fff : prod_q[22:8];
  assign ema_mv = acc_q[AccW-1:16];
  assign div_sh = 12'(div_q) << step_q;
  assign seg_diff = 9'(ema_mv - SocTable[seg_q]);

  // rank of the current candidate, ties broken by position
  always_comb begin
    rank = '0;
    for (int j = 0; j < MEDIAN_TAPS; j++) begin
      if ((ring_q[j] < ring_q[cand_q]) ||
          ((ring_q[j] == ring_q[cand_q]) && (SlotW'(j) < cand_q))) begin
        rank = rank + SlotW'(1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    alpha_d     = alpha_q;
    hold_d      = hold_q;
    pin_d       = pin_q;
    slot_d      = slot_q;
    cand_d      = cand_q;
    med_d       = med_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    primed_d    = primed_q;
    rep_d       = rep_q;
    has_rep_d   = has_rep_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    pct_d       = pct_q;
    seg_d       = seg_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q;
    out_mv_d    = out_mv_q;
    out_pct_d   = out_pct_q;
    out_lvl_d   = out_lvl_q;
    ring_fill   = 1'b0;
    ring_wr     = 1'b0;

    if (cfg_wr) begin
      case (paddr[3:2])
        RegDividerGain: gain_d  = pwdata[GainW-1:0];
        RegEmaAlpha:    alpha_d = pwdata[AlphaW-1:0];
        RegRiseHoldoff: hold_d  = pwdata[HoldW-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          pin_d   = pin_mv_i;
          state_d = sample_ok_i ? StScale : StDone;
        end
      end
      StScale: begin
        state_d = StScaled;
      end
      StScaled: begin
        if (!primed_q) begin
          ring_fill = 1'b1;
          slot_d    = FirstNext;
          acc_d     = {mv_now, 16'h0000};
          primed_d  = 1'b1;
          state_d   = StSeg;
        end else begin
          ring_wr = 1'b1;
          slot_d  = (slot_q >= LastSlot) ? '0 : slot_q + SlotW'(1);
          cand_d  = '0;
          state_d = StMedian;
        end
      end
      StMedian: begin
        if (rank == MidRank) begin
          med_d   = ring_q[cand_q];
          state_d = StMulA;
        end else begin
          cand_d = cand_q + SlotW'(1);
        end
      end
      StMulA: begin
        state_d = StMulB;
      end
      StMulB: begin
        sum_d   = prod_q[AccW-1:0];
        state_d = StAccum;
      end
      StAccum: begin
        acc_d   = AccW'(32'(sum_q) + prod_q[47:16]);
        state_d = StSeg;
      end
      StSeg: begin
        seg_d = '0;
        if (ema_mv >= SocTable[SocPts-1]) begin
          pct_d   = PctFull;
          state_d = StReport;
        end else if (ema_mv <= SocTable[0]) begin
          pct_d   = '0;
          state_d = StReport;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (ema_mv <= SocTable[seg_q + SegW'(1)]) begin
          rem_d   = {1'b0, seg_diff, 3'b000} + {3'b000, seg_diff, 1'b0};
          div_d   = 9'(SocTable[seg_q + SegW'(1)] - SocTable[seg_q]);
          step_d  = 2'd3;
          quo_d   = '0;
          state_d = StDivide;
        end else begin
          seg_d = seg_q + SegW'(1);
        end
      end
      StDivide: begin
        if (rem_q >= 13'(div_sh)) begin
          rem_d = rem_q - 13'(div_sh);
          quo_d = {quo_q[2:0], 1'b1};
        end else begin
          quo_d = {quo_q[2:0], 1'b0};
        end
        if (step_q == 2'd0) begin
          state_d = StReport;
        end else begin
          step_d = step_q - 2'd1;
        end
      end
      StReport: begin
        if (!has_rep_q) begin
          rep_d     = pct_q;
          has_rep_d = 1'b1;
          pend_d    = 1'b0;
          cnt_d     = '0;
        end else if (pct_q > rep_q) begin
          if (!pend_q) begin
            pend_d = 1'b1;
            cnt_d  = '0;
          end else if (cnt_q >= hold_q) begin
            rep_d  = pct_q;
            pend_d = 1'b0;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_q + HoldW'(1);
          end
        end else begin
          if (pct_q < rep_q) begin
            rep_d = pct_q;
          end
          pend_d = 1'b0;
          cnt_d  = '0;
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mv_d    = primed_q ? ema_mv : '0;
          out_pct_d   = primed_q ? rep_q : '0;
          out_lvl_d   = primed_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // percent from the finished divide feeds the report stage
    if (state_q == StDivide && step_q == 2'd0) begin
      pct_d = PctW'({seg_q, 3'b000}) + PctW'({seg_q, 1'b0}) +
              PctW'(quo_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gain_q      <= GainReset;
      alpha_q     <= AlphaReset;
      hold_q      <= HoldReset;
      slot_q      <= '0;
      acc_q       <= '0;
      primed_q    <= 1'b0;
      rep_q       <= '0;
      has_rep_q   <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_mv_q    <= '0;
      out_pct_q   <= '0;
      out_lvl_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      alpha_q     <= alpha_d;
      hold_q      <= hold_d;
      slot_q      <= slot_d;
      acc_q       <= acc_d;
      primed_q    <= primed_d;
      rep_q       <= rep_d;
      has_rep_q   <= has_rep_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_mv_q    <= out_mv_d;
      out_pct_q   <= out_pct_d;
      out_lvl_q   <= out_lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pin_q     <= pin_d;
    cand_q    <= cand_d;
    med_q     <= med_d;
    sum_q     <= sum_d;
    prod_q    <= prod_d;
    pct_q     <= pct_d;
    seg_q     <= seg_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    step_q    <= step_d;
    quo_q     <= quo_d;
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (ring_fill) begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        ring_q[i] <= mv_now;
      end
    end else if (ring_wr) begin
      ring_q[slot_q] <= mv_now;
    end
  end

  assign in_ready_o       = (state_q == StIdle);
  assign out_valid_o      = out_valid_q;
  assign filtered_mv_o    = out_mv_q;
  assign charge_percent_o = out_pct_q;
  assign level_valid_o    = out_lvl_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_percent_o <= PctFull)
    else $error("charge percent above full scale");

  a_unprimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !level_valid_o) |-> (filtered_mv_o == '0 && charge_percent_o == '0))
    else $error("unprimed result carries data");

  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("primed flag dropped");

  a_count_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> pend_q)
    else $error("rise count without pending rise");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastSlot)
    else $error("ring slot out of range");

endmodule
